### hw/rtl/wpd_pkg.sv
// ============================================================================
// Weighted pool draw package
// Shared types, command and status codes, and sizing constants for the
// weighted pool draw unit.
// ============================================================================
package wpd_pkg;

    localparam int POOL_DEPTH_DEF = 64;
    localparam int SUM_W          = 38;
    localparam int VAL_W          = 32;
    localparam int WGT_W          = 32;
    localparam int CNT_OUT_W      = 7;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_APPEND   = 3'd1;
    localparam logic [2:0] CMD_PICK_U   = 3'd2;
    localparam logic [2:0] CMD_TAKE_U   = 3'd3;
    localparam logic [2:0] CMD_PICK_W   = 3'd4;
    localparam logic [2:0] CMD_TAKE_W   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]              cmd;
        logic signed [VAL_W-1:0] entry_value;
        logic [WGT_W-1:0]        entry_weight;
        logic [SUM_W-1:0]        draw;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] chosen_value;
        logic [1:0]              status;
        logic [CNT_OUT_W-1:0]    remaining_count;
        logic [SUM_W-1:0]        total_weight;
    } t_result;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [WGT_W-1:0]        weight;
    } t_entry;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [SUM_W:0] sum;
        logic           lt;
    } t_alu_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_UREAD,
        S_SCAN,
        S_LREAD
    } t_state;

endpackage

### hw/rtl/wpd_store.sv
// ============================================================================
// Weighted pool draw entry store
// Single write port, single registered read port memory holding the value
// and weight pairs of the pool.
// ============================================================================
module wpd_store #(
    parameter int DEPTH = wpd_pkg::POOL_DEPTH_DEF,
    parameter int IW    = $clog2(wpd_pkg::POOL_DEPTH_DEF)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  wpd_pkg::t_entry i_wdata,
    input  logic [IW-1:0]   i_raddr,
    output wpd_pkg::t_entry o_rdata
);
    import wpd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/wpd_alu.sv
// ============================================================================
// Weighted pool draw shared arithmetic unit
// One 39-bit adder or subtractor with a compare of the draw against its
// result, shared by append, scan and remove steps.
// ============================================================================
module wpd_alu (
    input  wpd_pkg::t_alu_op              i_op,
    input  logic [wpd_pkg::SUM_W-1:0]     i_a,
    input  logic [wpd_pkg::WGT_W-1:0]     i_b,
    input  logic [wpd_pkg::SUM_W-1:0]     i_draw,
    output wpd_pkg::t_alu_res             o_res
);
    import wpd_pkg::*;

    logic [SUM_W:0] a_ext;
    logic [SUM_W:0] b_ext;
    logic [SUM_W:0] sum;

    assign a_ext = {1'b0, i_a};
    assign b_ext = (SUM_W+1)'(i_b);
    assign sum   = (i_op == ALU_ADD) ? (a_ext + b_ext) : (a_ext - b_ext);

    assign o_res.sum = sum;
    assign o_res.lt  = ({1'b0, i_draw} < sum);

endmodule

### hw/rtl/weighted_pool_draw_unit.sv
// ============================================================================
// Weighted pool draw unit
// Pool of value and weight pairs with clear, append, uniform and weighted
// pick or take commands, run by a small sequencer over one shared adder.
// ============================================================================
// Clear, append and rejected commands finish in the execute state. A uniform
// pick reads the drawn slot; a take then also reads the last slot, moves it
// into the hole and shrinks the pool. A weighted draw scans from slot 0 and
// ends at the slot it lands on; the scan reads one weight per cycle from the store.
// A new command is accepted in the strobe cycle; the receiver cannot stall.
// Synchronous reset empties the pool at once; the store itself is not cleared.
module weighted_pool_draw_unit #(
    parameter int POOL_DEPTH = wpd_pkg::POOL_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  wpd_pkg::t_item   i_item,
    output logic             o_valid,
    output wpd_pkg::t_result o_result
);
    import wpd_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    t_state           r_state, n_state;
    t_item            r_item, n_item;
    logic [CW-1:0]    r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pidx, n_pidx;
    logic [SUM_W-1:0] r_acc, n_acc;
    logic [IW-1:0]    r_idx, n_idx;
    logic [VAL_W-1:0] r_chosen, n_chosen;
    logic [WGT_W-1:0] r_wsel, n_wsel;
    t_result          r_out, n_out;
    logic             r_valid, n_valid;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic [IW-1:0]    mem_raddr;
    t_entry           mem_rdata;

    t_alu_op          alu_op;
    logic [SUM_W-1:0] alu_a;
    logic [WGT_W-1:0] alu_b;
    t_alu_res         alu_res;

    logic             fin;
    logic [VAL_W-1:0] fin_val;
    logic [1:0]       fin_status;
    logic [CW-1:0]    last;
    logic             is_take;
    logic             hit;

    wpd_store #(
        .DEPTH (POOL_DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    wpd_alu u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_draw (r_item.draw),
        .o_res  (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_addr   <= n_addr;
        r_pidx   <= n_pidx;
        r_acc    <= n_acc;
        r_idx    <= n_idx;
        r_chosen <= n_chosen;
        r_wsel   <= n_wsel;
        r_out    <= n_out;
    end

    assign last    = r_count - CW'(1);
    assign is_take = (r_item.cmd == CMD_TAKE_U) || (r_item.cmd == CMD_TAKE_W);
    assign hit     = r_pend && (((mem_rdata.weight != '0) && alu_res.lt) ||
                                (r_pidx == last[IW-1:0]));

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_count    = r_count;
        n_sum      = r_sum;
        n_addr     = r_addr;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_acc      = r_acc;
        n_idx      = r_idx;
        n_chosen   = r_chosen;
        n_wsel     = r_wsel;
        n_out      = r_out;
        n_valid    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_count[IW-1:0];
        mem_wdata  = '{value: r_item.entry_value, weight: r_item.entry_weight};
        mem_raddr  = r_addr[IW-1:0];
        alu_op     = ALU_ADD;
        alu_a      = r_sum;
        alu_b      = r_item.entry_weight;
        fin        = 1'b0;
        fin_val    = '0;
        fin_status = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_item.cmd)
                    CMD_CLEAR: begin
                        n_count = '0;
                        n_sum   = '0;
                        fin     = 1'b1;
                    end
                    CMD_APPEND: begin
                        fin = 1'b1;
                        if ((r_count >= CW'(POOL_DEPTH)) || alu_res.sum[SUM_W]) begin
                            fin_status = ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_sum   = alu_res.sum[SUM_W-1:0];
                        end
                    end
                    CMD_PICK_U, CMD_TAKE_U: begin
                        if (r_count == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else if (r_item.draw >= SUM_W'(r_count)) begin
                            fin        = 1'b1;
                            fin_status = ST_RANGE;
                        end else begin
                            mem_raddr = r_item.draw[IW-1:0];
                            n_idx     = r_item.draw[IW-1:0];
                            n_state   = S_UREAD;
                        end
                    end
                    CMD_PICK_W, CMD_TAKE_W: begin
                        alu_b = '0;
                        if ((r_count == '0) || (r_sum == '0)) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else if (!alu_res.lt) begin
                            fin        = 1'b1;
                            fin_status = ST_RANGE;
                        end else begin
                            n_addr  = '0;
                            n_pend  = 1'b0;
                            n_acc   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_UREAD: begin
                n_chosen = mem_rdata.value;
                n_wsel   = mem_rdata.weight;
                if (is_take) begin
                    mem_raddr = last[IW-1:0];
                    n_state   = S_LREAD;
                end else begin
                    fin     = 1'b1;
                    fin_val = mem_rdata.value;
                end
            end
            S_SCAN: begin
                alu_a     = r_acc;
                alu_b     = mem_rdata.weight;
                mem_raddr = r_addr[IW-1:0];
                n_pidx    = r_addr[IW-1:0];
                n_pend    = 1'b1;
                if (r_addr < r_count) begin
                    n_addr = r_addr + CW'(1);
                end
                if (r_pend && (mem_rdata.weight != '0)) begin
                    n_acc = alu_res.sum[SUM_W-1:0];
                end
                if (hit) begin
                    n_pend   = 1'b0;
                    n_idx    = r_pidx;
                    n_chosen = mem_rdata.value;
                    n_wsel   = mem_rdata.weight;
                    if (is_take) begin
                        mem_raddr = last[IW-1:0];
                        n_state   = S_LREAD;
                    end else begin
                        fin     = 1'b1;
                        fin_val = mem_rdata.value;
                    end
                end
            end
            S_LREAD: begin
                alu_op    = ALU_SUB;
                alu_b     = r_wsel;
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_sum     = alu_res.sum[SUM_W-1:0];
                n_count   = last;
                fin       = 1'b1;
                fin_val   = r_chosen;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_out.chosen_value    = fin_val;
            n_out.status          = fin_status;
            n_out.remaining_count = CNT_OUT_W'(n_count);
            n_out.total_weight    = n_sum;
            n_valid               = 1'b1;
            n_state               = S_IDLE;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(POOL_DEPTH))
        else $error("pool count exceeds depth");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_sum == '0))
        else $error("empty pool holds a nonzero weight total");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the unit busy");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a command in progress");
`endif

endmodule
